/* src/gpat_pkg.sv */
// Shared types and constants for the gyro P-gain autotuner.
`default_nettype none

package gpat_pkg;

    localparam int NUM_AXES   = 3;
    localparam int AXIS_W     = 2;
    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = 24;
    localparam int GAIN_W     = 16;
    localparam int WAIT_W     = 16;
    localparam int SETTLE_W   = 15;
    localparam int AVGC_W     = 8;
    localparam int POWER_W    = 4;
    localparam int LIMIT_W    = 16;
    localparam int P_W        = 8;
    localparam int FRAC_BITS  = 6;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int DIV_CNT_W  = $clog2(SUM_W);

    typedef logic [AXIS_W-1:0] t_axis;
    localparam t_axis AXIS_YAW = 2'd2;

    // Quantization masks: multiples of 128 on roll/pitch, of 32 on yaw
    localparam logic [SAMPLE_W-1:0] RP_Q_MASK  = 16'hFF80;
    localparam logic [SAMPLE_W-1:0] YAW_Q_MASK = 16'hFFE0;

    localparam logic signed [17:0] THR_RP  = 18'sd10;
    localparam logic signed [17:0] THR_YAW = 18'sd20;

    localparam logic [GAIN_W-1:0] STEP_UP_RP  = 16'd64;
    localparam logic [GAIN_W-1:0] STEP_UP_YAW = 16'd256;
    localparam logic [GAIN_W-1:0] STEP_DN_RP  = 16'd32;
    localparam logic [GAIN_W-1:0] STEP_DN_YAW = 16'd64;

    typedef enum logic [2:0] {
        REG_SETTLE    = 3'd0,
        REG_AVERAGE   = 3'd1,
        REG_POWER     = 3'd2,
        REG_ROLL_LIM  = 3'd3,
        REG_PITCH_LIM = 3'd4,
        REG_YAW_LIM   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [SETTLE_W-1:0]               settle_cycles;
        logic [AVGC_W-1:0]                 average_cycles;
        logic [POWER_W-1:0]                tune_power;
        logic [NUM_AXES-1:0][LIMIT_W-1:0]  limits;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_FIX,
        S_CMP,
        S_UPD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
        logic div_start;
        logic fix;
        logic cmp;
        logic upd;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic axis_ok;
        logic need_div;
        logic div_done;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

/* src/gpat_div.sv */
// Radix-2 restoring divider: unsigned window sum by the average count.
`default_nettype none

module gpat_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [gpat_pkg::SUM_W-1:0]   i_dividend,
    input  wire logic [gpat_pkg::AVGC_W-1:0]  i_divisor,
    output logic                              o_done,
    output logic [gpat_pkg::SUM_W-1:0]        o_quotient
);
    import gpat_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [AVGC_W-1:0]    r_rem;
    logic [SUM_W-1:0]     r_quo;

    logic [AVGC_W:0]      rem_sh;
    logic                 ge;

    // dividend bits shift out of r_quo as quotient bits shift in
    assign rem_sh = {r_rem, r_quo[SUM_W-1]};
    assign ge     = rem_sh >= {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(SUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? AVGC_W'(rem_sh - {1'b0, i_divisor}) : rem_sh[AVGC_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

/* src/gpat_dp.sv */
// Datapath: per-axis tuner state, window accumulation, gain update, output register.
`default_nettype none

module gpat_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire gpat_pkg::t_cfg                 i_cfg,
    input  wire gpat_pkg::t_dp_cmd              i_cmd,
    output gpat_pkg::t_dp_sts                   o_sts,
    input  wire logic                           i_command,
    input  wire logic [gpat_pkg::AXIS_W-1:0]    i_axis,
    input  wire logic                           i_stick_active,
    input  wire logic                           i_level_mode,
    input  wire logic signed [gpat_pkg::SAMPLE_W-1:0] i_gyro_sample,
    input  wire logic [gpat_pkg::P_W-1:0]       i_initial_p,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [gpat_pkg::AXIS_W-1:0]         o_result_axis,
    output logic                                o_p_updated,
    output logic [gpat_pkg::P_W-1:0]            o_new_p,
    output logic                                o_average_done,
    output logic signed [gpat_pkg::SAMPLE_W-1:0] o_average_rate
);
    import gpat_pkg::*;

    // captured item
    logic                       r_cmd_start;
    t_axis                      r_axis;
    logic                       r_stick;
    logic                       r_level;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [P_W-1:0]             r_init_p;

    // per-axis state
    logic signed [WAIT_W-1:0]   r_wait [NUM_AXES];
    logic signed [SUM_W-1:0]    r_sum  [NUM_AXES];
    logic signed [SAMPLE_W-1:0] r_prev [NUM_AXES];
    logic signed [GAIN_W-1:0]   r_gain [NUM_AXES];

    // window decision pipeline
    logic                       r_neg;
    logic [SUM_W-1:0]           r_avg;
    logic signed [SAMPLE_W-1:0] r_err;
    logic [GAIN_W-1:0]          r_delta;
    logic                       r_apply;

    // pending result
    logic                       r_res_upd;
    logic [P_W-1:0]             r_res_p;
    logic                       r_res_done;
    logic [SAMPLE_W-1:0]        r_res_avg;

    // output register
    logic                       r_o_valid;
    t_axis                      r_o_axis;
    logic                       r_o_upd;
    logic [P_W-1:0]             r_o_p;
    logic                       r_o_done;
    logic [SAMPLE_W-1:0]        r_o_avg;

    logic                       axis_ok;
    logic                       is_yaw;
    logic                       hold;
    logic [LIMIT_W-1:0]         lim;
    logic [P_W-1:0]             lo;
    logic [P_W-1:0]             hi;
    logic [P_W-1:0]             p_start;
    logic [WAIT_W-1:0]          neg_settle;
    logic signed [WAIT_W-1:0]   wc_old;
    logic signed [WAIT_W-1:0]   wc_new;
    logic signed [SUM_W-1:0]    sum_base;
    logic signed [SUM_W-1:0]    sum_new;
    logic [SAMPLE_W-1:0]        q_mask;
    logic [SAMPLE_W-1:0]        q_biased;
    logic [SAMPLE_W-1:0]        q_val;
    logic                       win_end;
    logic [SUM_W-1:0]           sum_mag;
    logic                       div_done;
    logic [SUM_W-1:0]           quotient;
    logic [SUM_W-1:0]           avg_s;
    logic [SAMPLE_W-1:0]        err_s;
    logic signed [SAMPLE_W-1:0] old_err;
    logic [SAMPLE_W:0]          mag_e;
    logic [SAMPLE_W:0]          mag_o;
    logic signed [17:0]         diff;
    logic signed [17:0]         thr;
    logic                       err_pos;
    logic                       old_pos;
    logic                       same_sign;
    logic                       diff_hi;
    logic                       diff_lo;
    logic [GAIN_W-1:0]          delta;
    logic [GAIN_W-1:0]          tp_ext;
    logic signed [GAIN_W-1:0]   g_new;
    logic signed [GAIN_W-FRAC_BITS:0] g_shift;
    logic [P_W-1:0]             p_clamped;

    assign axis_ok = r_axis < AXIS_W'(NUM_AXES);
    assign is_yaw  = r_axis == AXIS_YAW;
    assign hold    = r_stick || (!is_yaw && r_level);

    // limits; an inverted pair disables tuning
    assign lim = i_cfg.limits[r_axis];
    assign lo  = lim[P_W-1:0];
    assign hi  = (lim[LIMIT_W-1:P_W] != '0 && lo > lim[LIMIT_W-1:P_W]) ? '0
                                                                        : lim[LIMIT_W-1:P_W];

    assign p_start    = (r_init_p < lo) ? lo : r_init_p;
    assign neg_settle = WAIT_W'(0) - WAIT_W'({1'b0, i_cfg.settle_cycles});

    // sample tick accumulation
    assign wc_old   = r_wait[r_axis];
    assign wc_new   = wc_old + 16'sd1;
    assign sum_base = (wc_old == '0) ? '0 : r_sum[r_axis];
    assign q_mask   = is_yaw ? YAW_Q_MASK : RP_Q_MASK;
    // truncate toward zero: bias negative values before masking
    assign q_biased = r_sample + (r_sample[SAMPLE_W-1] ? ~q_mask : '0);
    assign q_val    = q_biased & q_mask;
    assign sum_new  = (wc_new > 16'sd0)
                      ? sum_base + {{(SUM_W-SAMPLE_W){q_val[SAMPLE_W-1]}}, q_val}
                      : sum_base;
    assign win_end  = (i_cfg.average_cycles != '0)
                      && (wc_new == {{(WAIT_W-AVGC_W){1'b0}}, i_cfg.average_cycles});
    assign sum_mag  = sum_new[SUM_W-1] ? SUM_W'(0) - sum_new : sum_new;

    gpat_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (sum_mag),
        .i_divisor  (i_cfg.average_cycles),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // sign fix and error
    assign avg_s = r_neg ? SUM_W'(0) - quotient : quotient;
    assign err_s = is_yaw ? SAMPLE_W'(0) - avg_s[SAMPLE_W-1:0] : avg_s[SAMPLE_W-1:0];

    // compare against the previous error
    assign old_err   = r_prev[r_axis];
    assign mag_e     = r_err[SAMPLE_W-1] ? (SAMPLE_W+1)'(0) - {r_err[SAMPLE_W-1], r_err}
                                         : {1'b0, r_err};
    assign mag_o     = old_err[SAMPLE_W-1] ? (SAMPLE_W+1)'(0) - {old_err[SAMPLE_W-1], old_err}
                                           : {1'b0, old_err};
    assign diff      = $signed({1'b0, mag_e}) - $signed({1'b0, mag_o});
    assign thr       = is_yaw ? THR_YAW : THR_RP;
    assign diff_hi   = diff > thr;
    assign diff_lo   = diff < -thr;
    assign err_pos   = !r_err[SAMPLE_W-1] && r_err != '0;
    assign old_pos   = !old_err[SAMPLE_W-1] && old_err != '0;
    assign same_sign = (err_pos && old_pos) || (r_err[SAMPLE_W-1] && old_err[SAMPLE_W-1]);
    assign tp_ext    = {{(GAIN_W-POWER_W){1'b0}}, i_cfg.tune_power};

    always_comb begin
        delta = '0;
        if (same_sign) begin
            if (diff_hi) begin
                delta = (is_yaw ? STEP_UP_YAW : STEP_UP_RP) + tp_ext;
            end else if (diff_lo) begin
                delta = GAIN_W'(0) - (is_yaw ? STEP_DN_YAW + tp_ext : STEP_DN_RP);
            end
        end else if ((diff_hi || diff_lo) && !is_yaw) begin
            delta = GAIN_W'(0) - STEP_DN_RP;
        end
    end

    // gain step, floor shift, clamp
    assign g_new   = r_gain[r_axis] + r_delta;
    assign g_shift = {g_new[GAIN_W-1], g_new[GAIN_W-1:FRAC_BITS]};

    always_comb begin
        if (g_shift < $signed({3'b000, lo})) begin
            p_clamped = lo;
        end else if (g_shift > $signed({3'b000, hi})) begin
            p_clamped = hi;
        end else begin
            p_clamped = g_shift[P_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd_start <= i_command;
            r_axis      <= i_axis;
            r_stick     <= i_stick_active;
            r_level     <= i_level_mode;
            r_sample    <= i_gyro_sample;
            r_init_p    <= i_initial_p;
        end
        if (i_cmd.div_start) begin
            r_neg <= sum_new[SUM_W-1];
        end
        if (i_cmd.fix) begin
            r_avg <= avg_s;
            r_err <= err_s;
        end
        if (i_cmd.cmp) begin
            r_delta <= delta;
            r_apply <= hi != '0 && r_err != '0 && old_err != '0 && r_err != old_err;
        end
    end

    // per-axis state and pending result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r_wait[i] <= '0;
                r_sum[i]  <= '0;
                r_prev[i] <= '0;
                r_gain[i] <= '0;
            end
        end else if (i_cmd.exec && axis_ok) begin
            r_res_upd  <= 1'b0;
            r_res_p    <= '0;
            r_res_done <= 1'b0;
            r_res_avg  <= '0;
            priority if (r_cmd_start) begin
                r_gain[r_axis] <= {{(GAIN_W-P_W-FRAC_BITS){1'b0}}, p_start, FRAC_BITS'(0)};
                r_prev[r_axis] <= '0;
                r_wait[r_axis] <= neg_settle;
                r_res_upd      <= 1'b1;
                r_res_p        <= p_start;
            end else if (hold) begin
                r_prev[r_axis] <= '0;
                r_wait[r_axis] <= neg_settle;
            end else begin
                r_wait[r_axis] <= wc_new;
                r_sum[r_axis]  <= sum_new;
            end
        end else if (i_cmd.upd) begin
            r_sum[r_axis]  <= r_avg;
            r_wait[r_axis] <= '0;
            r_prev[r_axis] <= r_err;
            r_res_done     <= 1'b1;
            r_res_avg      <= r_avg[SAMPLE_W-1:0];
            if (r_apply) begin
                r_gain[r_axis] <= g_new;
                r_res_upd      <= 1'b1;
                r_res_p        <= p_clamped;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_axis <= r_axis;
            r_o_upd  <= r_res_upd;
            r_o_p    <= r_res_p;
            r_o_done <= r_res_done;
            r_o_avg  <= r_res_avg;
        end
    end

    assign o_sts.axis_ok  = axis_ok;
    assign o_sts.need_div = axis_ok && !r_cmd_start && !hold && win_end;
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !r_o_valid || i_out_ready;

    assign o_out_valid    = r_o_valid;
    assign o_result_axis  = r_o_axis;
    assign o_p_updated    = r_o_upd;
    assign o_new_p        = r_o_p;
    assign o_average_done = r_o_done;
    assign o_average_rate = r_o_avg;

endmodule

`default_nettype wire

/* src/gpat_ctrl.sv */
// Sequencer: steps one item through execute and, when a window closes, divide, fix, compare and update.
`default_nettype none

module gpat_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire gpat_pkg::t_dp_sts i_sts,
    output gpat_pkg::t_dp_cmd      o_cmd
);
    import gpat_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                priority if (!i_sts.axis_ok) n_state = S_IDLE;
                else if (i_sts.need_div)     n_state = S_DIV;
                else                         n_state = S_DONE;
            end
            S_DIV: begin
                if (i_sts.div_done) n_state = S_FIX;
            end
            S_FIX:  n_state = S_CMP;
            S_CMP:  n_state = S_UPD;
            S_UPD:  n_state = S_DONE;
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.exec      = 1'b1;
                o_cmd.div_start = i_sts.need_div;
            end
            S_DIV:  ;
            S_FIX:  o_cmd.fix = 1'b1;
            S_CMP:  o_cmd.cmp = 1'b1;
            S_UPD:  o_cmd.upd = 1'b1;
            S_DONE: o_cmd.load_out = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

/* src/gpat_regs.sv */
// APB register file for the tuner configuration.
`default_nettype none

module gpat_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [gpat_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [gpat_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [gpat_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready,
    output gpat_pkg::t_cfg                        o_cfg
);
    import gpat_pkg::*;

    logic [SETTLE_W-1:0] r_settle;
    logic [AVGC_W-1:0]   r_avgc;
    logic [POWER_W-1:0]  r_power;
    logic [LIMIT_W-1:0]  r_lim [NUM_AXES];

    logic     wr_en;
    t_reg_idx idx;

    assign wr_en  = psel && penable && pwrite;
    assign idx    = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= 15'd128;
            r_avgc   <= 8'd16;
            r_power  <= '0;
            for (int i = 0; i < NUM_AXES; i++) begin
                r_lim[i] <= 16'h640A;
            end
        end else if (wr_en) begin
            unique case (idx)
                REG_SETTLE:    r_settle <= pwdata[SETTLE_W-1:0];
                REG_AVERAGE:   r_avgc   <= pwdata[AVGC_W-1:0];
                REG_POWER:     r_power  <= pwdata[POWER_W-1:0];
                REG_ROLL_LIM:  r_lim[0] <= pwdata[LIMIT_W-1:0];
                REG_PITCH_LIM: r_lim[1] <= pwdata[LIMIT_W-1:0];
                REG_YAW_LIM:   r_lim[2] <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_SETTLE:    prdata = APB_DATA_W'(r_settle);
            REG_AVERAGE:   prdata = APB_DATA_W'(r_avgc);
            REG_POWER:     prdata = APB_DATA_W'(r_power);
            REG_ROLL_LIM:  prdata = APB_DATA_W'(r_lim[0]);
            REG_PITCH_LIM: prdata = APB_DATA_W'(r_lim[1]);
            REG_YAW_LIM:   prdata = APB_DATA_W'(r_lim[2]);
            default:       prdata = '0;
        endcase
    end

    always_comb begin
        o_cfg.settle_cycles  = r_settle;
        o_cfg.average_cycles = r_avgc;
        o_cfg.tune_power     = r_power;
        for (int i = 0; i < NUM_AXES; i++) begin
            o_cfg.limits[i] = r_lim[i];
        end
    end

endmodule

`default_nettype wire

/* src/gyro_p_gain_autotuner.sv */
// Per-axis P gain autotuner: one result per accepted item on axes 0..2, none on axis 3.
// Start, stick and mid-window ticks pass through the execute and done states only; a tick that
// closes an averaging window also runs the 24-step divider and the fix, compare and update states.
// One item in flight; the next item is taken once the result sits in the output register.
// Reset (synchronous, active low) zeroes all axis state and restores the register defaults.
`default_nettype none

module gyro_p_gain_autotuner (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [gpat_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [gpat_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [gpat_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic                             i_command,
    input  wire logic [gpat_pkg::AXIS_W-1:0]      i_axis,
    input  wire logic                             i_stick_active,
    input  wire logic                             i_level_mode,
    input  wire logic signed [gpat_pkg::SAMPLE_W-1:0] i_gyro_sample,
    input  wire logic [gpat_pkg::P_W-1:0]         i_initial_p,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic [gpat_pkg::AXIS_W-1:0]           o_result_axis,
    output logic                                  o_p_updated,
    output logic [gpat_pkg::P_W-1:0]              o_new_p,
    output logic                                  o_average_done,
    output logic signed [gpat_pkg::SAMPLE_W-1:0]  o_average_rate
);
    import gpat_pkg::*;

    t_cfg    cfg;
    t_dp_cmd cmd;
    t_dp_sts sts;

    gpat_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    gpat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gpat_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_command      (i_command),
        .i_axis         (i_axis),
        .i_stick_active (i_stick_active),
        .i_level_mode   (i_level_mode),
        .i_gyro_sample  (i_gyro_sample),
        .i_initial_p    (i_initial_p),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_axis  (o_result_axis),
        .o_p_updated    (o_p_updated),
        .o_new_p        (o_new_p),
        .o_average_done (o_average_done),
        .o_average_rate (o_average_rate)
    );

endmodule

`default_nettype wire

/* src/gpat_chk.sv */
// Port-level checker for the autotuner, bound to the top level.
`default_nettype none

module gpat_chk (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             pready,
    input wire logic                             o_out_valid,
    input wire logic                             i_out_ready,
    input wire logic [gpat_pkg::AXIS_W-1:0]      o_result_axis,
    input wire logic                             o_p_updated,
    input wire logic [gpat_pkg::P_W-1:0]         o_new_p,
    input wire logic                             o_average_done,
    input wire logic signed [gpat_pkg::SAMPLE_W-1:0] o_average_rate
);
    import gpat_pkg::*;

    // a stalled transfer keeps its valid
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped while stalled");

    // a stalled transfer keeps its payload
    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_result_axis) && $stable(o_p_updated)
            && $stable(o_new_p) && $stable(o_average_done) && $stable(o_average_rate))
        else $error("output payload changed while stalled");

    // unused axis never yields a result
    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_result_axis != 2'd3)
        else $error("result on unused axis");

    // gain field is zero unless a gain was written
    a_p_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_p_updated |-> o_new_p == '0)
        else $error("new_p set without p_updated");

    // average is zero unless a window closed; a start never closes one
    a_avg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_average_done |-> o_average_rate == '0 && pready)
        else $error("average_rate set without average_done");

endmodule

bind gyro_p_gain_autotuner gpat_chk u_chk (.*);

`default_nettype wire
